>>> hdl/smpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sparse max-times aggregate block.
// No dependencies; imported by sparse_max_product_aggregate and smpa_mac.
package smpa_pkg;

   localparam int DATA_W   = 16;   // Q8.8 feature word and edge weight
   localparam int MAX_W    = 32;   // Q16.16 product and running maximum
   localparam int COL_W    = 8;    // argmax column
   localparam int ENTRY_W  = MAX_W + COL_W;
   localparam int ACT_W    = 5;

   localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;
   localparam logic [MAX_W-1:0] EMPTY_MAX = 32'h8000_0000;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_PROCESS = 2'd1,
      CMD_READ    = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH,
      ST_RDWAIT,
      ST_RESP
   } state_type;

   // one feature update handed to the multiply/compare unit
   typedef struct packed {
      logic vld;   // slot carries an update
      logic hit;   // row entry already holds a maximum
   } issue_type;

endpackage

>>> hdl/sparse_max_product_aggregate.sv
`timescale 1ns / 1ps
// A process request steps through the active feature count;
// the multiply/compare unit takes one feature a cycle.
// Throughput: one request at a time; the next one is taken after the
// response register has been loaded. Reset (synchronous, active high) empties
// all rows and sets the active feature count to 16; stores are not cleared.
// Depends on smpa_pkg, smpa_ram and smpa_mac.
module sparse_max_product_aggregate #(
   parameter int ROWS     = 256,
   parameter int NODES    = 256,
   parameter int FEATURES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [4:0]          csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [7:0]          req_row_index,
   input  logic [7:0]          req_column_index,
   input  logic [3:0]          req_feature_index,
   input  logic signed [15:0]  req_data_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_max_value,
   output logic [7:0]          rsp_argmax_column,
   output logic                rsp_found,
   output logic                rsp_done_res
);
   import smpa_pkg::*;

   localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int FCW = $clog2(FEATURES + 1);
   localparam int FAW = $clog2(NODES * FEATURES);
   localparam int EAW = $clog2(ROWS * FEATURES);

   state_type state_ff, state_in;

   cmd_type            cmd_ff;
   logic [7:0]         row_ff, col_ff;
   logic [3:0]         feat_ff;
   logic signed [15:0] data_ff;
   logic [ACT_W-1:0]   active_ff;
   logic [FAW-1:0]     fbase_ff, fbase_in;
   logic [EAW-1:0]     ebase_ff, ebase_in;
   logic [FCW-1:0]     j_ff, j_in;
   logic [ROWS-1:0]    row_seen_ff;

   logic               rsp_valid_ff;
   logic [MAX_W-1:0]   rsp_max_ff, rsp_max_in;
   logic [COL_W-1:0]   rsp_arg_ff, rsp_arg_in;
   logic               rsp_found_ff, rsp_found_in;

   logic [RW-1:0]      rowi;
   logic [NW-1:0]      coli;
   logic               row_ok, col_ok, feat_ok;
   logic               req_fire, out_free;
   logic [FCW-1:0]     n_feat, old_vcnt, new_vcnt, vc_rdata;
   logic [DATA_W-1:0]  feat_rdata;
   logic [ENTRY_W-1:0] ent_rdata, ent_wdata;
   logic [EAW-1:0]     ent_waddr;
   logic               ent_we, mac_busy;
   logic               feat_we, vc_we, seen_set, seen_clr, rsp_load, rd_hit;
   issue_type          iss;

   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rowi    = RW'(row_ff);
   assign coli    = NW'(col_ff);
   assign row_ok  = 32'(row_ff) < ROWS;
   assign col_ok  = 32'(col_ff) < NODES;
   assign feat_ok = 32'(feat_ff) < FEATURES;

   // active count clamped to 1..FEATURES
   always_comb begin
      if (active_ff == '0) begin
         n_feat = FCW'(1);
      end else if (32'(active_ff) > FEATURES) begin
         n_feat = FCW'(FEATURES);
      end else begin
         n_feat = FCW'(active_ff);
      end
   end

   // entries 0..old_vcnt-1 of a row are filled; an unseen row has none
   assign old_vcnt = (row_ok && row_seen_ff[rowi]) ? vc_rdata : '0;
   assign new_vcnt = (old_vcnt > n_feat) ? old_vcnt : n_feat;

   assign fbase_in = FAW'(coli * FEATURES);
   assign ebase_in = EAW'(rowi * FEATURES);

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            case (cmd_ff)
               CMD_LOAD:    state_in = ST_LOAD;
               CMD_PROCESS: state_in = (row_ok && col_ok) ? ST_RUN : ST_RESP;
               CMD_READ:    state_in = ST_RDWAIT;
               default:     state_in = ST_RESP;
            endcase
         end
         ST_LOAD:   state_in = ST_RESP;
         ST_RUN: begin
            if (j_ff == n_feat - FCW'(1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!mac_busy) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_RESP;
         ST_RDWAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_stall = 1'b1;
      feat_we   = 1'b0;
      vc_we     = 1'b0;
      seen_set  = 1'b0;
      seen_clr  = 1'b0;
      rsp_load  = 1'b0;
      iss       = '0;
      j_in      = j_ff;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SETUP: begin
            j_in     = (cmd_ff == CMD_READ) ? FCW'(feat_ff) : '0;
            seen_clr = (cmd_ff == CMD_CLEAR);
         end
         ST_LOAD:   feat_we = col_ok && feat_ok;
         ST_RUN: begin
            iss.vld = 1'b1;
            iss.hit = j_ff < old_vcnt;
            j_in    = j_ff + FCW'(1);
         end
         ST_FINISH: begin
            vc_we    = 1'b1;
            seen_set = 1'b1;
         end
         ST_RESP:   rsp_load = out_free;
         default:   ;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         active_ff   <= ACT_RESET;
         row_seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) active_ff <= csr_wr_data;
         if (seen_clr) begin
            row_seen_ff <= '0;
         end else if (seen_set) begin
            row_seen_ff[rowi] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= cmd_type'(req_cmd);
         row_ff  <= req_row_index;
         col_ff  <= req_column_index;
         feat_ff <= req_feature_index;
         data_ff <= req_data_value;
      end
      if (state_ff == ST_SETUP) begin
         fbase_ff <= fbase_in;
         ebase_ff <= ebase_in;
      end
      j_ff <= j_in;
      if (rsp_load) begin
         rsp_max_ff   <= rsp_max_in;
         rsp_arg_ff   <= rsp_arg_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

   // read answer; non-read commands return zeros
   assign rd_hit = (cmd_ff == CMD_READ) && row_ok && feat_ok && (j_ff < old_vcnt);

   always_comb begin
      rsp_max_in   = '0;
      rsp_arg_in   = '0;
      rsp_found_in = rd_hit;
      if (cmd_ff == CMD_READ) begin
         rsp_max_in = rd_hit ? ent_rdata[ENTRY_W-1:COL_W] : EMPTY_MAX;
         rsp_arg_in = rd_hit ? ent_rdata[COL_W-1:0] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_max_value     = $signed(rsp_max_ff);
   assign rsp_argmax_column = rsp_arg_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_done_res      = 1'b1;

   // ---------------- storage ----------------
   smpa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NODES * FEATURES)
   ) u_feat_ram (
      .clock   (clock),
      .wr_en   (feat_we),
      .wr_addr (fbase_ff + FAW'(feat_ff)),
      .wr_data (data_ff),
      .rd_addr (fbase_ff + FAW'(j_ff)),
      .rd_data (feat_rdata)
   );

   smpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ROWS * FEATURES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ebase_ff + EAW'(j_ff)),
      .rd_data (ent_rdata)
   );

   // per-row count of filled entries
   smpa_ram #(
      .WIDTH (FCW),
      .DEPTH (ROWS)
   ) u_vcnt_ram (
      .clock   (clock),
      .wr_en   (vc_we),
      .wr_addr (rowi),
      .wr_data (new_vcnt),
      .rd_addr (rowi),
      .rd_data (vc_rdata)
   );

   smpa_mac #(
      .AW (EAW)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .iss           (iss),
      .iss_addr      (ebase_ff + EAW'(j_ff)),
      .feat_word     ($signed(feat_rdata)),
      .weight        (data_ff),
      .old_entry_max (ent_rdata[ENTRY_W-1:COL_W]),
      .column        (col_ff),
      .busy          (mac_busy),
      .wr_en         (ent_we),
      .wr_addr       (ent_waddr),
      .wr_data       (ent_wdata)
   );

   // ---------------- checks ----------------
   a_vcnt_after_drain: assert property (@(posedge clock) disable iff (reset)
      vc_we |-> !mac_busy)
      else $error("row fill count written while updates in flight");

   a_entry_wr_window: assert property (@(posedge clock) disable iff (reset)
      ent_we |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("row entry written outside a process request");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      iss.vld |-> (j_ff < n_feat))
      else $error("feature update issued past the active count");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside the response state");

endmodule

>>> hdl/smpa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/smpa_mac.sv
`timescale 1ns / 1ps
// Shared multiply/compare unit: one feature product per cycle, compared
// against the stored row maximum. Depends on smpa_pkg.
module smpa_mac #(
   parameter int AW = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  smpa_pkg::issue_type        iss,
   input  logic [AW-1:0]              iss_addr,
   input  logic signed [15:0]         feat_word,
   input  logic signed [15:0]         weight,
   input  logic [31:0]                old_entry_max,
   input  logic [7:0]                 column,
   output logic                       busy,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [smpa_pkg::ENTRY_W-1:0] wr_data
);
   import smpa_pkg::*;

   // stage 1: RAM reads in flight
   issue_type s1_ff, s1_in;
   logic [AW-1:0] a1_ff;
   // stage 2: product and old maximum registered
   issue_type s2_ff, s2_in;
   logic [AW-1:0] a2_ff;
   logic signed [MAX_W-1:0] prod_ff, prod_in;
   logic signed [MAX_W-1:0] old_ff;

   assign s1_in   = iss;
   assign s2_in   = s1_ff;
   assign prod_in = MAX_W'(feat_word) * MAX_W'(weight);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff   <= iss_addr;
      a2_ff   <= a1_ff;
      prod_ff <= prod_in;
      old_ff  <= $signed(old_entry_max);
   end

   // first product of an empty entry always lands; ties keep the older column
   assign wr_en   = s2_ff.vld && (!s2_ff.hit || (prod_ff > old_ff));
   assign wr_addr = a2_ff;
   assign wr_data = {prod_ff, column};
   assign busy    = s1_ff.vld || s2_ff.vld;

endmodule

>>> tb/tb_sparse_max_product_aggregate.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_max_product_aggregate: directed corner requests,
// then random load/process/read/clear traffic at several feature counts.
// Depends on smpa_pkg and the block itself.
module tb_sparse_max_product_aggregate;
   import smpa_pkg::*;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [4:0]         csr_wr_data;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [7:0]         req_row_index;
   logic [7:0]         req_column_index;
   logic [3:0]         req_feature_index;
   logic signed [15:0] req_data_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_max_value;
   logic [7:0]         rsp_argmax_column;
   logic               rsp_found;
   logic               rsp_done_res;

   typedef struct {
      logic signed [31:0] max_value;
      logic [7:0]         argmax_column;
      logic               found;
      logic               done_res;
   } agg_result_type;

   // shadow of the block's state
   logic signed [15:0] feature_words [256][16];
   logic [15:0]        feature_written [256];
   logic signed [31:0] row_max [256][16];
   logic [7:0]         row_argmax [256][16];
   bit                 row_seen [256];
   bit                 entry_taken [256][16];
   logic [4:0]         active_reg;

   agg_result_type due_results [$];
   int mismatches = 0;
   int send_calm = 0;
   int rsp_calm = 0;
   int rsp_hold = 0;

   sparse_max_product_aggregate dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_row_index     (req_row_index),
      .req_column_index  (req_column_index),
      .req_feature_index (req_feature_index),
      .req_data_value    (req_data_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_max_value     (rsp_max_value),
      .rsp_argmax_column (rsp_argmax_column),
      .rsp_found         (rsp_found),
      .rsp_done_res      (rsp_done_res)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // 0 acts as 1, anything above 16 acts as 16
   function automatic int active_count();
      if (active_reg == 5'd0) return 1;
      if (active_reg > 5'd16) return 16;
      return active_reg;
   endfunction

   // wait cycles per request; occasional stretches with no waiting at all
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
      return $urandom_range(0, 4);
   endfunction

   function automatic logic signed [15:0] pick_word();
      logic signed [15:0] extremes [5];
      extremes = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0100};
      case ($urandom_range(0, 9))
         0: return extremes[$urandom_range(0, 4)];
         1, 2: return 16'($signed($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   // update of the shadow state and expected response for one accepted request
   function automatic agg_result_type aggregate_step(cmd_type c, logic [7:0] row,
                                                     logic [7:0] col, logic [3:0] feat,
                                                     logic signed [15:0] data);
      agg_result_type res;
      logic signed [31:0] prod;
      res = '{max_value: 32'sd0, argmax_column: 8'd0, found: 1'b0, done_res: 1'b1};
      case (c)
         CMD_LOAD: begin
            feature_words[col][feat] = data;
            feature_written[col][feat] = 1'b1;
         end
         CMD_PROCESS: begin
            for (int j = 0; j < active_count(); j++) begin
               prod = feature_words[col][j] * data;
               if (!entry_taken[row][j] || prod > row_max[row][j]) begin
                  row_max[row][j] = prod;
                  row_argmax[row][j] = col;
                  entry_taken[row][j] = 1'b1;
               end
            end
            row_seen[row] = 1'b1;
         end
         CMD_READ: begin
            res.max_value = EMPTY_MAX;
            if (row_seen[row] && entry_taken[row][feat]) begin
               res.max_value = row_max[row][feat];
               res.argmax_column = row_argmax[row][feat];
               res.found = 1'b1;
            end
         end
         default: begin
            foreach (row_seen[r]) begin
               row_seen[r] = 1'b0;
               for (int j = 0; j < 16; j++) entry_taken[r][j] = 1'b0;
            end
         end
      endcase
      return res;
   endfunction

   task automatic send_request(cmd_type c, logic [7:0] row, logic [7:0] col,
                               logic [3:0] feat, logic signed [15:0] data);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_row_index <= row;
      req_column_index <= col;
      req_feature_index <= feat;
      req_data_value <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_results.push_back(aggregate_step(c, row, col, feat, data));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_active_features(logic [4:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_reg = value;
   endtask

   task automatic test_empty_reads();
      send_request(CMD_READ, 8'd0, 8'd0, 4'd0, 16'sd0);
      send_request(CMD_READ, 8'd255, 8'd255, 4'd15, 16'sh7FFF);
      send_request(CMD_CLEAR, 8'd0, 8'd0, 4'd0, 16'sd0);
   endtask

   // expects two active features
   task automatic test_tie_and_extremes();
      send_request(CMD_LOAD, 8'd0, 8'd0, 4'd0, 16'sh7FFF);
      send_request(CMD_LOAD, 8'd0, 8'd0, 4'd1, 16'sh8000);
      send_request(CMD_LOAD, 8'd0, 8'd255, 4'd0, 16'sh7FFF);
      send_request(CMD_LOAD, 8'd0, 8'd255, 4'd1, 16'sh8000);
      send_request(CMD_PROCESS, 8'd3, 8'd255, 4'd0, 16'sh8000);
      // equal products: the earlier column keeps the entry
      send_request(CMD_PROCESS, 8'd3, 8'd0, 4'd0, 16'sh8000);
      send_request(CMD_PROCESS, 8'd3, 8'd0, 4'd0, 16'sh7FFF);
      send_request(CMD_PROCESS, 8'd4, 8'd0, 4'd0, 16'sd0);
      send_request(CMD_READ, 8'd3, 8'd0, 4'd0, 16'sd0);
      send_request(CMD_READ, 8'd3, 8'd0, 4'd1, 16'sd0);
      // row seen but entry beyond the active count never taken
      send_request(CMD_READ, 8'd3, 8'd0, 4'd2, 16'sd0);
      send_request(CMD_READ, 8'd4, 8'd0, 4'd0, 16'sd0);
   endtask

   task automatic test_clear_rows();
      send_request(CMD_CLEAR, 8'd255, 8'd255, 4'd15, 16'shFFFF);
      send_request(CMD_READ, 8'd3, 8'd0, 4'd1, 16'sd0);
      send_request(CMD_PROCESS, 8'd255, 8'd255, 4'd0, 16'shFFFF);
      send_request(CMD_READ, 8'd255, 8'd0, 4'd1, 16'sd0);
   endtask

   task automatic test_random_traffic(int count);
      int kind;
      int n;
      int miss;
      logic [7:0] row;
      logic [7:0] col;
      logic [3:0] feat;
      n = active_count();
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         // small row and column pools so maxima build up over many nonzeros
         row = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
         col = ($urandom_range(0, 19) < 17) ? 8'($urandom_range(0, 23)) : 8'($urandom);
         feat = 4'($urandom);
         if (kind < 45) begin
            miss = -1;
            for (int j = n - 1; j >= 0; j--) if (!feature_written[col][j]) miss = j;
            // a nonzero may only use features that were loaded
            if (miss >= 0) send_request(CMD_LOAD, row, col, 4'(miss), pick_word());
            else send_request(CMD_PROCESS, row, col, feat, pick_word());
         end else if (kind < 70) begin
            send_request(CMD_LOAD, row, col, feat, pick_word());
         end else if (kind < 98) begin
            send_request(CMD_READ, row, col, feat, pick_word());
         end else begin
            send_request(CMD_CLEAR, row, col, feat, pick_word());
         end
      end
   endtask

   always @(posedge clock) begin
      agg_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected response, max %h argmax %h found %b done %b", $time,
                     rsp_max_value, rsp_argmax_column, rsp_found, rsp_done_res);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            if (rsp_max_value !== want.max_value) begin
               $display("%0t: max_value expected %h actual %h", $time, want.max_value,
                        rsp_max_value);
               mismatches++;
            end
            if (rsp_argmax_column !== want.argmax_column) begin
               $display("%0t: argmax_column expected %h actual %h", $time,
                        want.argmax_column, rsp_argmax_column);
               mismatches++;
            end
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %b actual %b", $time, want.found, rsp_found);
               mismatches++;
            end
            if (rsp_done_res !== want.done_res) begin
               $display("%0t: done_res expected %b actual %b", $time, want.done_res,
                        rsp_done_res);
               mismatches++;
            end
         end
         rsp_hold = draw_wait(rsp_calm);
      end else if (rsp_valid && rsp_stall && rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold != 0);
   end

   initial begin
      logic [4:0] sweep [6];
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 5'd0;
      req_valid <= 1'b0;
      req_cmd <= CMD_LOAD;
      req_row_index <= 8'd0;
      req_column_index <= 8'd0;
      req_feature_index <= 4'd0;
      req_data_value <= 16'sd0;
      rsp_stall <= 1'b0;
      active_reg = ACT_RESET;
      foreach (row_seen[r]) begin
         row_seen[r] = 1'b0;
         feature_written[r] = 16'd0;
         for (int j = 0; j < 16; j++) entry_taken[r][j] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_reads();
      set_active_features(5'd2);
      test_tie_and_extremes();
      test_clear_rows();

      // 0 and 31 are outside the legal range and clamp to 1 and 16
      sweep = '{5'd1, 5'd16, 5'd0, 5'd31, 5'($urandom_range(2, 15)),
                5'($urandom_range(17, 30))};
      foreach (sweep[k]) begin
         set_active_features(sweep[k]);
         test_random_traffic(275);
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
